// ===== hw/rtl/lpa_pkg.sv =====
// Shared types, widths, register indexes and reset values for the lens phase adder.
// Depends on nothing; included by scoped reference from lens_phase_adder.
`default_nettype none

package lpa_pkg;

    // Default values of the top-level parameters.
    localparam int MAX_DIM_DEF    = 4096;
    localparam int PHASE_BITS_DEF = 16;

    // Fixed field widths.
    localparam int DIM_W   = 13;
    localparam int IDX_W   = 12;
    localparam int PITCH_W = 24;
    localparam int WORD_W  = 32;
    localparam int MAG_W   = 14;
    localparam int OFS_W   = 38;
    localparam int HALF_W  = 19;
    localparam int ROOT_W  = 38;
    localparam int SUM_W   = 2 * ROOT_W;
    localparam int FRAC_W  = 33;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_FRAME_WIDTH    = 3'd0;
    localparam cfg_idx_t CFG_FRAME_HEIGHT   = 3'd1;
    localparam cfg_idx_t CFG_PIXEL_PITCH_X  = 3'd2;
    localparam cfg_idx_t CFG_PIXEL_PITCH_Y  = 3'd3;
    localparam cfg_idx_t CFG_FOCAL_LENGTH   = 3'd4;
    localparam cfg_idx_t CFG_INV_WAVELENGTH = 3'd5;

    localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST    = 13'd1024;
    localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST   = 13'd1024;
    localparam logic [PITCH_W-1:0] PIXEL_PITCH_RST    = 24'd524;
    localparam logic [WORD_W-1:0]  FOCAL_LENGTH_RST   = 32'd6553600;
    localparam logic [WORD_W-1:0]  INV_WAVELENGTH_RST = 32'd61603840;

    // Distance of a pixel from the frame center in half pixels: |2*index - size - 1|.
    function automatic logic [MAG_W-1:0] offset_mag(
        input logic [IDX_W-1:0] index,
        input logic [DIM_W-1:0] size
    );
        logic [MAG_W-1:0] a;
        logic [MAG_W-1:0] b;
        a = {1'b0, index, 1'b0};
        b = MAG_W'(size) + MAG_W'(1);
        offset_mag = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lens_phase_adder.sv =====
// Top level of the lens phase adder: config registers, pipelined offset, square,
// square root and phase wrap datapath, with an output skid stage. Uses lpa_pkg.
`default_nettype none

// Channel   Signals                                        Direction
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data       in (write)
// in        in_valid, in_ready, phase_in, row, column       in
// out       out_valid, out_ready, phase_out                 out
//
// One request enters per cycle while the skid stage is empty. The square root
// resolves one root bit per stage over 38 stages. Reset clears all valid bits
// and loads the register defaults. A stalled output holds the whole pipeline
// only once the skid stage behind the output register is full; config writes
// are taken in every cycle.
module lens_phase_adder #(
    parameter int MAX_DIM    = lpa_pkg::MAX_DIM_DEF,
    parameter int PHASE_BITS = lpa_pkg::PHASE_BITS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [lpa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [lpa_pkg::WORD_W-1:0]          cfg_data,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [PHASE_BITS-1:0]               phase_in,
    input  wire  [lpa_pkg::IDX_W-1:0]           row,
    input  wire  [lpa_pkg::IDX_W-1:0]           column,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [PHASE_BITS-1:0]               phase_out
);

    localparam int DIM_W   = lpa_pkg::DIM_W;
    localparam int PITCH_W = lpa_pkg::PITCH_W;
    localparam int WORD_W  = lpa_pkg::WORD_W;
    localparam int MAG_W   = lpa_pkg::MAG_W;
    localparam int OFS_W   = lpa_pkg::OFS_W;
    localparam int HALF_W  = lpa_pkg::HALF_W;
    localparam int RW      = lpa_pkg::ROOT_W;
    localparam int SW      = lpa_pkg::SUM_W;
    localparam int FRAC_W  = lpa_pkg::FRAC_W;
    localparam int PROD_W  = 2 * HALF_W;
    localparam int TERM_W  = FRAC_W + WORD_W;
    localparam int PHASE_SHIFT = FRAC_W - PHASE_BITS;

    // Configuration registers.
    logic [DIM_W-1:0]   frame_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;
    logic [PITCH_W-1:0] pixel_pitch_x_reg;
    logic [PITCH_W-1:0] pixel_pitch_y_reg;
    logic [WORD_W-1:0]  focal_length_reg;
    logic [WORD_W-1:0]  inv_wavelength_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= lpa_pkg::FRAME_WIDTH_RST;
            frame_height_reg   <= lpa_pkg::FRAME_HEIGHT_RST;
            pixel_pitch_x_reg  <= lpa_pkg::PIXEL_PITCH_RST;
            pixel_pitch_y_reg  <= lpa_pkg::PIXEL_PITCH_RST;
            focal_length_reg   <= lpa_pkg::FOCAL_LENGTH_RST;
            inv_wavelength_reg <= lpa_pkg::INV_WAVELENGTH_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lpa_pkg::CFG_FRAME_WIDTH:    frame_width_reg    <= cfg_data[DIM_W-1:0];
                lpa_pkg::CFG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data[DIM_W-1:0];
                lpa_pkg::CFG_PIXEL_PITCH_X:  pixel_pitch_x_reg  <= cfg_data[PITCH_W-1:0];
                lpa_pkg::CFG_PIXEL_PITCH_Y:  pixel_pitch_y_reg  <= cfg_data[PITCH_W-1:0];
                lpa_pkg::CFG_FOCAL_LENGTH:   focal_length_reg   <= cfg_data;
                lpa_pkg::CFG_INV_WAVELENGTH: inv_wavelength_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Derived values; user keeps registers fixed with requests in flight (unenforced).
    logic [DIM_W-1:0]  width_sat;
    logic [DIM_W-1:0]  height_sat;
    logic              focal_neg;
    logic              focal_zero;
    logic [WORD_W-1:0] focal_mag;
    logic [FRAC_W-1:0] focal_twice;

    assign width_sat   = (32'(frame_width_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : frame_width_reg;
    assign height_sat  = (32'(frame_height_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : frame_height_reg;
    assign focal_neg   = focal_length_reg[WORD_W-1];
    assign focal_mag   = focal_neg ? (~focal_length_reg + WORD_W'(1)) : focal_length_reg;
    assign focal_zero  = (focal_length_reg == '0);
    assign focal_twice = {focal_mag, 1'b0};

    logic en;

    // Stage 1: distances from the center in half pixels.
    logic                  s1_v_reg;
    logic [PHASE_BITS-1:0] s1_ph_reg;
    logic [MAG_W-1:0]      s1_mx_reg;
    logic [MAG_W-1:0]      s1_my_reg;

    // Stage 2: scaled offsets.
    logic                  s2_v_reg;
    logic [PHASE_BITS-1:0] s2_ph_reg;
    logic [OFS_W-1:0]      s2_dx_reg;
    logic [OFS_W-1:0]      s2_dy_reg;

    // Stage 3: partial products of the three squares (x, y, focal).
    logic                  s3_v_reg;
    logic [PHASE_BITS-1:0] s3_ph_reg;
    logic [PROD_W-1:0]     s3_hh_reg [0:2];
    logic [PROD_W-1:0]     s3_hl_reg [0:2];
    logic [PROD_W-1:0]     s3_ll_reg [0:2];

    // Stage 4: whole squares.
    logic                  s4_v_reg;
    logic [PHASE_BITS-1:0] s4_ph_reg;
    logic [SW-1:0]         s4_sq_reg [0:2];

    logic [OFS_W-1:0] sq_src [0:2];
    assign sq_src[0] = s2_dx_reg;
    assign sq_src[1] = s2_dy_reg;
    assign sq_src[2] = OFS_W'(focal_twice);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ph_reg <= phase_in;
            s1_mx_reg <= lpa_pkg::offset_mag(column, width_sat);
            s1_my_reg <= lpa_pkg::offset_mag(row, height_sat);
            s2_ph_reg <= s1_ph_reg;
            s2_dx_reg <= OFS_W'(pixel_pitch_x_reg) * OFS_W'(s1_mx_reg);
            s2_dy_reg <= OFS_W'(pixel_pitch_y_reg) * OFS_W'(s1_my_reg);
            s3_ph_reg <= s2_ph_reg;
            s4_ph_reg <= s3_ph_reg;
            for (int k = 0; k < 3; k++)
            begin
                s3_hh_reg[k] <= PROD_W'(sq_src[k][OFS_W-1:HALF_W])
                              * PROD_W'(sq_src[k][OFS_W-1:HALF_W]);
                s3_hl_reg[k] <= PROD_W'(sq_src[k][OFS_W-1:HALF_W])
                              * PROD_W'(sq_src[k][HALF_W-1:0]);
                s3_ll_reg[k] <= PROD_W'(sq_src[k][HALF_W-1:0])
                              * PROD_W'(sq_src[k][HALF_W-1:0]);
                s4_sq_reg[k] <= SW'({s3_hh_reg[k], {(2 * HALF_W){1'b0}}})
                              + SW'({s3_hl_reg[k], {(HALF_W + 1){1'b0}}})
                              + SW'(s3_ll_reg[k]);
            end
        end
    end

    // Square root pipeline; index 0 holds the summed radicand.
    logic                  sq_v_reg    [0:RW];
    logic [PHASE_BITS-1:0] sq_ph_reg   [0:RW];
    logic [SW-1:0]         sq_rad_reg  [0:RW];
    logic [RW-1:0]         sq_root_reg [0:RW];
    logic [RW+1:0]         sq_rem_reg  [0:RW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_v_reg[0] <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_ph_reg[0]   <= s4_ph_reg;
            sq_rad_reg[0]  <= s4_sq_reg[0] + s4_sq_reg[1] + s4_sq_reg[2];
            sq_root_reg[0] <= '0;
            sq_rem_reg[0]  <= '0;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < RW; gi++)
        begin : g_root
            logic [RW+1:0] rem_sh;
            logic [RW+1:0] trial;
            logic          take;

            assign rem_sh = {sq_rem_reg[gi][RW-1:0], sq_rad_reg[gi][SW-1:SW-2]};
            assign trial  = {sq_root_reg[gi], 2'b01};
            assign take   = (rem_sh >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_v_reg[gi+1] <= 1'b0;
                end
                else if (en)
                begin
                    sq_v_reg[gi+1] <= sq_v_reg[gi];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_ph_reg[gi+1]   <= sq_ph_reg[gi];
                    sq_rad_reg[gi+1]  <= {sq_rad_reg[gi][SW-3:0], 2'b00};
                    sq_root_reg[gi+1] <= {sq_root_reg[gi][RW-2:0], take};
                    sq_rem_reg[gi+1]  <= take ? (rem_sh - trial) : rem_sh;
                end
            end
        end
    endgenerate

    // Path difference, then lens term in units of 2^-33 of a full phase turn.
    logic                    dd_v_reg;
    logic [PHASE_BITS-1:0]   dd_ph_reg;
    logic [FRAC_W-1:0]       dd_d_reg;
    logic                    mul_v_reg;
    logic [PHASE_BITS-1:0]   mul_ph_reg;
    logic [FRAC_W-1:0]       mul_term_reg;
    logic [TERM_W-1:0]       term_prod;

    assign term_prod = TERM_W'(dd_d_reg) * TERM_W'(inv_wavelength_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dd_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
        end
        else if (en)
        begin
            dd_v_reg  <= sq_v_reg[RW];
            mul_v_reg <= dd_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_ph_reg    <= sq_ph_reg[RW];
            dd_d_reg     <= sq_root_reg[RW][FRAC_W-1:0] - focal_twice;
            mul_ph_reg   <= dd_ph_reg;
            mul_term_reg <= term_prod[FRAC_W-1:0];
        end
    end

    // Phase wrap: the sum is kept modulo one cycle and rounded down.
    logic [FRAC_W-1:0]     acc_base;
    logic [FRAC_W-1:0]     acc_sum;
    logic [PHASE_BITS-1:0] result;

    assign acc_base = FRAC_W'(mul_ph_reg) << PHASE_SHIFT;

    always_comb
    begin
        if (focal_zero)
        begin
            acc_sum = acc_base;
        end
        else if (focal_neg)
        begin
            acc_sum = acc_base - mul_term_reg;
        end
        else
        begin
            acc_sum = acc_base + mul_term_reg;
        end
    end

    assign result = acc_sum[FRAC_W-1:PHASE_SHIFT];

    // Output register with a skid stage behind it.
    logic                  out_v_reg;
    logic                  out_v_next;
    logic [PHASE_BITS-1:0] out_d_reg;
    logic [PHASE_BITS-1:0] out_d_next;
    logic                  skid_v_reg;
    logic                  skid_v_next;
    logic [PHASE_BITS-1:0] skid_d_reg;
    logic [PHASE_BITS-1:0] skid_d_next;
    logic                  pop;

    assign en        = ~skid_v_reg;
    assign in_ready  = en;
    assign pop       = out_v_reg & out_ready;
    assign out_valid = out_v_reg;
    assign phase_out = out_d_reg;

    always_comb
    begin
        out_v_next  = out_v_reg;
        out_d_next  = out_d_reg;
        skid_v_next = skid_v_reg;
        skid_d_next = skid_d_reg;
        if (pop)
        begin
            out_v_next  = skid_v_reg;
            out_d_next  = skid_d_reg;
            skid_v_next = 1'b0;
        end
        if (en && mul_v_reg)
        begin
            if (!out_v_reg || pop)
            begin
                out_v_next = 1'b1;
                out_d_next = result;
            end
            else
            begin
                skid_v_next = 1'b1;
                skid_d_next = result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_d_reg  <= out_d_next;
        skid_d_reg <= skid_d_next;
    end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for lens_phase_adder: drives pixel requests and config writes through
// valid/ready channels and checks every phase_out against an in-bench lens phase predictor.
// Depends on lpa_pkg and the lens_phase_adder RTL.
`timescale 1ns / 1ps

class phase_scoreboard;
    logic [lpa_pkg::DIM_W-1:0]   frame_w;
    logic [lpa_pkg::DIM_W-1:0]   frame_h;
    logic [lpa_pkg::PITCH_W-1:0] pitch_x;
    logic [lpa_pkg::PITCH_W-1:0] pitch_y;
    logic [lpa_pkg::WORD_W-1:0]  focal;
    logic [lpa_pkg::WORD_W-1:0]  inv_wl;
    logic [15:0]                 phase_due[$];
    int                          fail_count;

    function new();
        frame_w    = lpa_pkg::FRAME_WIDTH_RST;
        frame_h    = lpa_pkg::FRAME_HEIGHT_RST;
        pitch_x    = lpa_pkg::PIXEL_PITCH_RST;
        pitch_y    = lpa_pkg::PIXEL_PITCH_RST;
        focal      = lpa_pkg::FOCAL_LENGTH_RST;
        inv_wl     = lpa_pkg::INV_WAVELENGTH_RST;
        fail_count = 0;
    endfunction

    function void set_reg(lpa_pkg::cfg_idx_t idx, logic [31:0] data);
        case (idx)
            lpa_pkg::CFG_FRAME_WIDTH:    frame_w = data[12:0];
            lpa_pkg::CFG_FRAME_HEIGHT:   frame_h = data[12:0];
            lpa_pkg::CFG_PIXEL_PITCH_X:  pitch_x = data[23:0];
            lpa_pkg::CFG_PIXEL_PITCH_Y:  pitch_y = data[23:0];
            lpa_pkg::CFG_FOCAL_LENGTH:   focal   = data;
            lpa_pkg::CFG_INV_WAVELENGTH: inv_wl  = data;
            default: ;
        endcase
    endfunction

    // Distance from the frame center in half pixels, scaled by the pitch.
    function logic [37:0] half_pixel_offset(logic [23:0] pitch, logic [11:0] index,
                                            logic [12:0] size);
        int          twice;
        int          span;
        logic [13:0] half_steps;
        if (size > 13'(lpa_pkg::MAX_DIM_DEF))
            size = 13'(lpa_pkg::MAX_DIM_DEF);
        twice      = 2 * int'(index);
        span       = int'(size) + 1;
        half_steps = 14'((twice >= span) ? twice - span : span - twice);
        return 38'(pitch) * 38'(half_steps);
    endfunction

    function logic [15:0] lens_phase(logic [15:0] ph, logic [11:0] r, logic [11:0] c);
        logic [37:0]  dx;
        logic [37:0]  dy;
        logic         neg;
        logic [31:0]  fmag;
        logic [32:0]  fmag2;
        logic [127:0] sum_sq;
        logic [127:0] trial_sq;
        logic [63:0]  root;
        logic [63:0]  trial;
        logic [63:0]  path_diff;
        logic [127:0] prod;
        logic [32:0]  acc;
        dx     = half_pixel_offset(pitch_x, c, frame_w);
        dy     = half_pixel_offset(pitch_y, r, frame_h);
        neg    = focal[31];
        fmag   = neg ? (~focal + 32'd1) : focal;
        fmag2  = {fmag, 1'b0};
        sum_sq = 128'(fmag2) * 128'(fmag2) + 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
        root   = '0;
        for (int b = 63; b >= 0; b--)
        begin
            trial    = root | (64'd1 << b);
            trial_sq = 128'(trial) * 128'(trial);
            if (trial_sq <= sum_sq)
                root = trial;
        end
        path_diff = root - 64'(fmag2);
        prod      = 128'(path_diff) * 128'(inv_wl);
        acc       = {ph, 17'b0};
        if (fmag != 0)
            acc = neg ? acc - prod[32:0] : acc + prod[32:0];
        return acc[32:17];
    endfunction

    function void note_pixel(logic [15:0] ph, logic [11:0] r, logic [11:0] c);
        phase_due.push_back(lens_phase(ph, r, c));
    endfunction

    function void check_phase(logic [15:0] got);
        logic [15:0] want;
        if (phase_due.size() == 0)
        begin
            if (fail_count < 100)
                $error("phase_out: expected none, actual %0d", got);
            fail_count++;
        end
        else
        begin
            want = phase_due.pop_front();
            if (got !== want)
            begin
                if (fail_count < 100)
                    $error("phase_out: expected %0d, actual %0d", want, got);
                fail_count++;
            end
        end
    endfunction

    function int pending();
        return phase_due.size();
    endfunction
endclass

module tb;
    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    lpa_pkg::cfg_idx_t       cfg_index;
    logic [31:0]             cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [15:0]             phase_in;
    logic [11:0]             row;
    logic [11:0]             column;
    logic                    out_valid;
    logic                    out_ready;
    logic [15:0]             phase_out;

    phase_scoreboard sb = new();
    int send_idle;
    int recv_idle;

    lens_phase_adder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .phase_in  (phase_in),
        .row       (row),
        .column    (column),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .phase_out (phase_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_phase(phase_out);
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic write_reg(lpa_pkg::cfg_idx_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic program_lens(logic [12:0] w, logic [12:0] h, logic [23:0] px,
                                logic [23:0] py, logic [31:0] f, logic [31:0] inv);
        write_reg(lpa_pkg::CFG_FRAME_WIDTH, 32'(w));
        write_reg(lpa_pkg::CFG_FRAME_HEIGHT, 32'(h));
        write_reg(lpa_pkg::CFG_PIXEL_PITCH_X, 32'(px));
        write_reg(lpa_pkg::CFG_PIXEL_PITCH_Y, 32'(py));
        write_reg(lpa_pkg::CFG_FOCAL_LENGTH, f);
        write_reg(lpa_pkg::CFG_INV_WAVELENGTH, inv);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(logic [15:0] ph, logic [11:0] r, logic [11:0] c);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        phase_in <= ph;
        row      <= r;
        column   <= c;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_pixel(ph, r, c);
    endtask

    task automatic drain_phases();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [12:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 13'($urandom_range(1, 4096));
        else if (r < 85)
            return ($urandom_range(1) != 0) ? 13'd1 : 13'd4096;
        else
            return 13'($urandom_range(0, 8191));
    endfunction

    function automatic logic [23:0] pick_pitch();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 24'($urandom_range(0, 2000));
        else if (r < 80)
            return 24'($urandom_range(0, 24'hFFFFFF));
        else
            return ($urandom_range(1) != 0) ? 24'hFFFFFF : 24'd0;
    endfunction

    function automatic logic [11:0] pick_index(logic [12:0] size);
        int span;
        if ($urandom_range(99) < 30)
            return 12'($urandom_range(0, 4095));
        span = (size == 0) ? 1 : ((size > 13'd4096) ? 4096 : int'(size));
        return 12'($urandom_range(0, span - 1));
    endfunction

    initial
    begin
        logic [12:0] w;
        logic [12:0] h;
        logic [31:0] f;
        logic [31:0] inv;
        int          r;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= lpa_pkg::CFG_FRAME_WIDTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        phase_in  <= '0;
        row       <= '0;
        column    <= '0;
        send_idle = 0;
        recv_idle = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_lens(13'd1024, 13'd1024, 24'd524, 24'd524, 32'd6553600, 32'd61603840);
        send_pixel(16'h0000, 12'd0, 12'd0);
        send_pixel(16'hFFFF, 12'd4095, 12'd4095);
        send_pixel(16'h8000, 12'd512, 12'd512);
        send_pixel(16'h1234, 12'd0, 12'd1023);
        send_pixel(16'hFFFF, 12'd1023, 12'd0);
        drain_phases();

        // Zero focal length passes the phase through.
        program_lens(13'd1024, 13'd1024, 24'd524, 24'd524, 32'd0, 32'd61603840);
        send_pixel(16'hABCD, 12'd100, 12'd900);
        send_pixel(16'hFFFF, 12'd4095, 12'd0);
        drain_phases();

        // Negative focal length subtracts the lens term and wraps below zero.
        program_lens(13'd1024, 13'd1024, 24'd524, 24'd524, -32'sd6553600, 32'd61603840);
        send_pixel(16'h0000, 12'd0, 12'd0);
        send_pixel(16'h0001, 12'd1023, 12'd1023);
        send_pixel(16'h7FFF, 12'd4095, 12'd4095);
        drain_phases();

        // Oversized and zero frame sizes, zero and full pitch, largest focal length.
        program_lens(13'd8191, 13'd0, 24'd0, 24'hFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
        send_pixel(16'h0000, 12'd0, 12'd0);
        send_pixel(16'hFFFF, 12'd4095, 12'd4095);
        send_pixel(16'h5555, 12'd1, 12'd2048);
        send_pixel(16'hAAAA, 12'd2048, 12'd1);
        drain_phases();

        program_lens(13'd1, 13'd4096, 24'hFFFFFF, 24'd1, 32'h80000000, 32'd0);
        send_pixel(16'h1357, 12'd0, 12'd0);
        send_pixel(16'h2468, 12'd4095, 12'd4095);
        drain_phases();

        program_lens(13'd4096, 13'd1, 24'd1, 24'd1, 32'd1, 32'hFFFFFFFF);
        send_pixel(16'h0000, 12'd2048, 12'd2048);
        send_pixel(16'hFFFF, 12'd0, 12'd4095);
        drain_phases();

        for (int p = 0; p < 9; p++)
        begin
            case (p / 3)
                0: begin send_idle = 29; recv_idle = 83; end
                1: begin send_idle = 83; recv_idle = 29; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            w = pick_size();
            h = pick_size();
            r = $urandom_range(99);
            if (r < 40)
                f = 32'($urandom_range(1 << 16, 1 << 28));
            else if (r < 70)
                f = ~32'($urandom_range(1 << 16, 1 << 28)) + 32'd1;
            else if (r < 80)
                f = 32'd0;
            else
                f = $urandom;
            inv = ($urandom_range(99) < 60) ? 32'($urandom_range(1 << 20, 1 << 28)) : $urandom;
            program_lens(w, h, pick_pitch(), pick_pitch(), f, inv);
            for (int i = 0; i < 195; i++)
                send_pixel(16'($urandom_range(0, 65535)), pick_index(h), pick_index(w));
            drain_phases();
        end

        repeat (60) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/lpa_pkg.sv
hw/rtl/lens_phase_adder.sv
dv/tb.sv
